// File: rtl/core/orlb_pkg.sv
// ----------------------------------------------------------------------------
// orlb_pkg
// Shared constants and types for the overwrite-oldest trace buffer.
// ----------------------------------------------------------------------------
package orlb_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int CAP_W     = 7;
  localparam int CAP_RESET_INT = (64 > MAX_DEPTH) ? MAX_DEPTH : 64;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_DEPTH);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic [7:0]  cpu_id;
    logic [63:0] time_stamp;
    logic [63:0] perf_count_a;
    logic [63:0] perf_count_b;
    logic [63:0] perf_count_c;
    logic [31:0] target_frequency;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage

// File: rtl/core/orlb_if.sv
// ----------------------------------------------------------------------------
// orlb interfaces
// Valid/ready channels for log input, drained records and capacity writes.
// ----------------------------------------------------------------------------
interface orlb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  cpu_id;
  logic [63:0] time_stamp;
  logic [63:0] perf_count_a;
  logic [63:0] perf_count_b;
  logic [63:0] perf_count_c;
  logic [31:0] target_frequency;

  modport source (output valid, operation, cpu_id, time_stamp, perf_count_a,
                  perf_count_b, perf_count_c, target_frequency, input ready);
  modport sink   (input valid, operation, cpu_id, time_stamp, perf_count_a,
                  perf_count_b, perf_count_c, target_frequency, output ready);
endinterface

interface orlb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_cpu_id;
  logic [63:0] out_time_stamp;
  logic [63:0] out_perf_count_a;
  logic [63:0] out_perf_count_b;
  logic [63:0] out_perf_count_c;
  logic [31:0] out_target_frequency;
  logic        data_lost;
  logic        last_record;

  modport source (output valid, out_cpu_id, out_time_stamp, out_perf_count_a,
                  out_perf_count_b, out_perf_count_c, out_target_frequency,
                  data_lost, last_record, input ready);
  modport sink   (input valid, out_cpu_id, out_time_stamp, out_perf_count_a,
                  out_perf_count_b, out_perf_count_c, out_target_frequency,
                  data_lost, last_record, output ready);
endinterface

interface orlb_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/overwrite_ring_log_buffer_core.sv
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer_core
// Overwrite-oldest circular trace buffer with drain-and-clear.
// ----------------------------------------------------------------------------
// An append transaction is taken every cycle while no drain is reading, and is
// written to the record RAM in that cycle. A drain transaction reads the valid
// records, oldest first, one RAM read per cycle, and holds off the input until
// the reads are issued; each record passes the RAM read register and then the
// output register, and output back-pressure throttles the reads. An empty drain
// issues no reads. Writing capacity clears the buffer.
module overwrite_ring_log_buffer_core
  import orlb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  orlb_cfg_if.sink   cfg,
  orlb_in_if.sink    log_in,
  orlb_out_if.source log_out
);

  logic [CAP_W-1:0]  capacity;
  logic [ADDR_W-1:0] insert_pointer;
  logic              wrapped;
  logic [CAP_W-1:0]  remaining;
  logic [ADDR_W-1:0] rd_addr;
  logic              drain_lost;
  logic              pend;
  logic              pend_last;
  logic              pend_lost;
  logic              out_valid;
  record_t           out_rec;
  logic              out_lost;
  logic              out_last;

  record_t           wr_rec;
  record_t           rd_rec;
  logic [REC_W-1:0]  rd_bits;
  logic              in_fire;
  logic              do_append;
  logic              do_drain;
  logic              cfg_fire;
  logic              issue;
  logic              move;
  logic [CAP_W-1:0]  ptr_inc;
  logic [CAP_W-1:0]  rd_inc;
  logic [CAP_W-1:0]  drain_count;
  logic [CAP_W-1:0]  cap_clamped;

  assign cfg.ready    = 1'b1;
  assign cfg_fire     = cfg.valid;
  assign log_in.ready = (remaining == '0);
  assign in_fire      = log_in.valid && log_in.ready;
  assign do_append    = in_fire && (log_in.operation == OP_APPEND);
  assign do_drain     = in_fire && (log_in.operation == OP_DRAIN);

  assign ptr_inc     = {1'b0, insert_pointer} + CAP_W'(1);
  assign rd_inc      = {1'b0, rd_addr} + CAP_W'(1);
  assign drain_count = wrapped ? capacity : {1'b0, insert_pointer};

  always_comb begin
    priority if (cfg.data == '0) begin
      cap_clamped = CAP_MIN;
    end else if (cfg.data > CAP_MAX) begin
      cap_clamped = CAP_MAX;
    end else begin
      cap_clamped = cfg.data;
    end
  end

  assign move  = pend && (!out_valid || log_out.ready);
  assign issue = (remaining != '0) && (!pend || move);

  assign wr_rec.cpu_id           = log_in.cpu_id;
  assign wr_rec.time_stamp       = log_in.time_stamp;
  assign wr_rec.perf_count_a     = log_in.perf_count_a;
  assign wr_rec.perf_count_b     = log_in.perf_count_b;
  assign wr_rec.perf_count_c     = log_in.perf_count_c;
  assign wr_rec.target_frequency = log_in.target_frequency;
  assign rd_rec                  = record_t'(rd_bits);

  orlb_ram #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (do_append),
    .waddr (insert_pointer),
    .wdata (wr_rec),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  // pointer, wrap flag and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      insert_pointer <= '0;
      wrapped        <= 1'b0;
    end else if (cfg_fire) begin
      capacity       <= cap_clamped;
      insert_pointer <= '0;
      wrapped        <= 1'b0;
    end else if (do_append) begin
      if (ptr_inc >= capacity) begin
        wrapped        <= 1'b1;
        insert_pointer <= '0;
      end else begin
        insert_pointer <= ptr_inc[ADDR_W-1:0];
      end
    end else if (do_drain) begin
      insert_pointer <= '0;
      wrapped        <= 1'b0;
    end
  end

  // drain read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (do_drain) begin
      remaining <= drain_count;
    end else if (issue) begin
      remaining <= remaining - CAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_drain) begin
      rd_addr    <= wrapped ? insert_pointer : '0;
      drain_lost <= wrapped;
    end else if (issue) begin
      rd_addr <= (rd_inc >= capacity) ? '0 : rd_inc[ADDR_W-1:0];
    end
  end

  // RAM data stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (log_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last <= (remaining == CAP_W'(1));
      pend_lost <= drain_lost;
    end
    if (move) begin
      out_rec  <= rd_rec;
      out_lost <= pend_lost;
      out_last <= pend_last;
    end
  end

  assign log_out.valid                = out_valid;
  assign log_out.out_cpu_id           = out_rec.cpu_id;
  assign log_out.out_time_stamp       = out_rec.time_stamp;
  assign log_out.out_perf_count_a     = out_rec.perf_count_a;
  assign log_out.out_perf_count_b     = out_rec.perf_count_b;
  assign log_out.out_perf_count_c     = out_rec.perf_count_c;
  assign log_out.out_target_frequency = out_rec.target_frequency;
  assign log_out.data_lost            = out_lost;
  assign log_out.last_record          = out_last;

  a_ptr_in_range : assert property (@(posedge clk) disable iff (rst)
    {1'b0, insert_pointer} < capacity)
    else $error("insert pointer beyond capacity");

  a_cap_range : assert property (@(posedge clk) disable iff (rst)
    (capacity >= CAP_MIN) && (capacity <= CAP_MAX))
    else $error("capacity out of range");

  a_last_done : assert property (@(posedge clk) disable iff (rst)
    issue && (remaining == CAP_W'(1)) |=> (remaining == '0) && pend && pend_last)
    else $error("last read did not close the drain");

  a_pend_hold : assert property (@(posedge clk) disable iff (rst)
    pend && !move |=> pend && $stable(pend_last) && $stable(pend_lost))
    else $error("pending read data lost");

  a_drain_empty_ptr : assert property (@(posedge clk) disable iff (rst)
    remaining != '0 |-> insert_pointer == '0 && !wrapped)
    else $error("buffer state not cleared during drain");

endmodule

// File: rtl/core/orlb_ram.sv
// ----------------------------------------------------------------------------
// orlb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module orlb_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: tb/overwrite_ring_log_buffer_core_tb.sv
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer_core_tb
// Self-checking bench for the overwrite-oldest trace buffer. Appends and
// drains are driven on the log channel with random gaps, and records are
// taken from the output channel with random stalls and one long hold-off.
// A scoreboard keeps its own copy of the ring, pointer and wrap flag. It
// queues the records each drain should emit and compares every drained
// record field by field. Capacity is rewritten between phases, including
// values that must be clamped.
// ----------------------------------------------------------------------------
module overwrite_ring_log_buffer_core_tb;
  import orlb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    record_t rec;
    logic    data_lost;
    logic    last_record;
  } drained_t;

  class trace_scoreboard;
    int unsigned cap;
    logic [ADDR_W-1:0] ptr;
    bit wrapped;
    record_t ring[MAX_DEPTH];
    drained_t drain_q[$];
    int errors;

    function new();
      cap     = 32'(CAP_RESET);
      ptr     = '0;
      wrapped = 1'b0;
      errors  = 0;
    endfunction

    function void apply_capacity(logic [CAP_W-1:0] v);
      if (v < CAP_MIN) cap = 32'(CAP_MIN);
      else if (v > CAP_MAX) cap = 32'(CAP_MAX);
      else cap = 32'(v);
      ptr     = '0;
      wrapped = 1'b0;
    endfunction

    function void note_input(logic op, record_t rec);
      int unsigned slot;
      int unsigned count;
      drained_t d;
      if (op == OP_APPEND) begin
        slot = ptr % cap;
        if (slot + 1 >= cap) wrapped = 1'b1;
        ring[slot] = rec;
        ptr = ADDR_W'((slot + 1) % cap);
      end else begin
        slot  = wrapped ? ptr % cap : 0;
        count = wrapped ? cap : ptr % cap;
        for (int unsigned i = 0; i < count; i++) begin
          d.rec         = ring[slot];
          d.data_lost   = wrapped;
          d.last_record = (i + 1 == count);
          drain_q.push_back(d);
          slot = (slot + 1) % cap;
        end
        ptr     = '0;
        wrapped = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(drained_t got);
      drained_t exp_r;
      if (drain_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual %0h", $time, got);
        return;
      end
      exp_r = drain_q.pop_front();
      compare_field("cpu_id", 64'(exp_r.rec.cpu_id), 64'(got.rec.cpu_id));
      compare_field("time_stamp", exp_r.rec.time_stamp, got.rec.time_stamp);
      compare_field("perf_count_a", exp_r.rec.perf_count_a, got.rec.perf_count_a);
      compare_field("perf_count_b", exp_r.rec.perf_count_b, got.rec.perf_count_b);
      compare_field("perf_count_c", exp_r.rec.perf_count_c, got.rec.perf_count_c);
      compare_field("target_frequency", 64'(exp_r.rec.target_frequency),
                    64'(got.rec.target_frequency));
      compare_field("data_lost", 64'(exp_r.data_lost), 64'(got.data_lost));
      compare_field("last_record", 64'(exp_r.last_record), 64'(got.last_record));
    endfunction

    function int pending();
      return drain_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  bit   in_idle;
  bit   out_idle;
  int   cycles;

  trace_scoreboard sb = new();

  orlb_cfg_if cfg_ch();
  orlb_in_if  log_in_ch();
  orlb_out_if log_out_ch();

  overwrite_ring_log_buffer_core dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .log_in  (log_in_ch),
    .log_out (log_out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic record_t random_record();
    record_t r;
    r.cpu_id           = 8'(pick64());
    r.time_stamp       = pick64();
    r.perf_count_a     = pick64();
    r.perf_count_b     = pick64();
    r.perf_count_c     = pick64();
    r.target_frequency = 32'(pick64());
    return r;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0: return 7'd1;
      1: return 7'd2;
      2: return CAP_W'($urandom_range(3, 8));
      3: return CAP_W'($urandom_range(9, 20));
      4: return CAP_W'($urandom_range(0, 127));
      default: return 7'd64;
    endcase
  endfunction

  task automatic send_item(input logic op, input record_t rec);
    int gap;
    gap = in_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      log_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    log_in_ch.valid            <= 1'b1;
    log_in_ch.operation        <= op;
    log_in_ch.cpu_id           <= rec.cpu_id;
    log_in_ch.time_stamp       <= rec.time_stamp;
    log_in_ch.perf_count_a     <= rec.perf_count_a;
    log_in_ch.perf_count_b     <= rec.perf_count_b;
    log_in_ch.perf_count_c     <= rec.perf_count_c;
    log_in_ch.target_frequency <= rec.target_frequency;
    do @(posedge clk); while (!log_in_ch.ready);
    sb.note_input(op, rec);
  endtask

  // outstanding records first, then let an empty drain finish
  task automatic wait_idle();
    log_in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.apply_capacity(v);
  endtask

  // record sink
  initial begin
    int gap;
    drained_t got;
    log_out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        log_out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end
      gap = out_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        log_out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      log_out_ch.ready <= 1'b1;
      do @(posedge clk); while (!log_out_ch.valid && !hold_req);
      if (log_out_ch.valid) begin
        got.rec.cpu_id           = log_out_ch.out_cpu_id;
        got.rec.time_stamp       = log_out_ch.out_time_stamp;
        got.rec.perf_count_a     = log_out_ch.out_perf_count_a;
        got.rec.perf_count_b     = log_out_ch.out_perf_count_b;
        got.rec.perf_count_c     = log_out_ch.out_perf_count_c;
        got.rec.target_frequency = log_out_ch.out_target_frequency;
        got.data_lost            = log_out_ch.data_lost;
        got.last_record          = log_out_ch.last_record;
        sb.check_result(got);
      end
    end
  end

  initial begin
    rst                        <= 1'b1;
    hold_req                   <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.data                <= '0;
    log_in_ch.valid            <= 1'b0;
    log_in_ch.operation        <= OP_APPEND;
    log_in_ch.cpu_id           <= '0;
    log_in_ch.time_stamp       <= '0;
    log_in_ch.perf_count_a     <= '0;
    log_in_ch.perf_count_b     <= '0;
    log_in_ch.perf_count_c     <= '0;
    log_in_ch.target_frequency <= '0;
    in_idle  = 1'b1;
    out_idle = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity: empty drain, then extreme records
    send_item(OP_DRAIN, random_record());
    send_item(OP_APPEND, '1);
    send_item(OP_APPEND, '0);
    send_item(OP_DRAIN, random_record());
    wait_idle();

    // zero clamps to one slot; first append already flags wrap
    write_capacity(7'd0);
    send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    send_item(OP_APPEND, random_record());
    send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    wait_idle();

    write_capacity(7'd127);
    repeat (3) send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    wait_idle();

    write_capacity(7'd3);
    repeat (3) send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    repeat (5) send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    send_item(OP_DRAIN, random_record());
    wait_idle();

    write_capacity(7'd65);
    send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    wait_idle();

    // full depth with a long output hold-off so the input backs up
    write_capacity(7'd64);
    in_idle  = 1'b0;
    out_idle = 1'b1;
    hold_req <= 1'b1;
    repeat (66) send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    repeat (8) send_item(OP_APPEND, random_record());
    send_item(OP_DRAIN, random_record());
    wait_idle();

    for (int p = 0; p < 2; p++) begin
      write_capacity(pick_capacity());
      in_idle  = ($urandom_range(0, 2) != 0);
      out_idle = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < 8; n++)
        send_item(($urandom_range(0, 5) == 0) ? OP_DRAIN : OP_APPEND, random_record());
      send_item(OP_DRAIN, random_record());
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
